FILE: design/bmmd_pkg.sv
package bmmd_pkg;

  localparam int ROM_PAGE_BITS = 7;
  localparam int RAM_PAGE_BITS = 2;
  localparam int OFFSET_BITS   = 21;

  // Cartridge kinds held in the configuration register.
  localparam logic [1:0] KIND_ROM_ONLY = 2'd0;
  localparam logic [1:0] KIND_MBC1     = 2'd1;
  localparam logic [1:0] KIND_MBC3     = 2'd2;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [15:0] ADDR_BOOT_EXIT = 16'h0100;
  localparam logic [15:0] ADDR_DMA       = 16'hFF46;
  localparam logic [3:0]  RAM_ENABLE_KEY = 4'hA;

  typedef enum logic [3:0] {
    REGION_BOOT     = 4'd0,
    REGION_ROM0     = 4'd1,
    REGION_ROMN     = 4'd2,
    REGION_VIDEO    = 4'd3,
    REGION_CARTRAM  = 4'd4,
    REGION_WORKRAM  = 4'd5,
    REGION_SPRITE   = 4'd6,
    REGION_UNUSABLE = 4'd7,
    REGION_IO       = 4'd8,
    REGION_HIGHRAM  = 4'd9,
    REGION_IRQ_EN   = 4'd10
  } region_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [ROM_PAGE_BITS-1:0] rom_page;
    logic [RAM_PAGE_BITS-1:0] ram_page;
    logic                     ram_enable;
    logic                     banking_mode;
    logic                     boot_overlay;
  } bank_state_t;

endpackage

FILE: design/bmmd_ctrl.sv
module bmmd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               update,
  input  bmmd_pkg::access_t  access,
  output bmmd_pkg::bank_state_t state_next
);
  import bmmd_pkg::*;

  logic [1:0]  cartridge_kind;
  bank_state_t state;

  logic [15:0] bank_tmp;
  logic [7:0]  ram_tmp;
  logic [ROM_PAGE_BITS-1:0] bank_fixed;
  logic [4:0]  low5;
  logic [6:0]  bank7;
  logic        is_mbc;

  always_comb begin
    state_next = state;
    bank_tmp   = 16'h0000;
    ram_tmp    = 8'h00;
    low5       = access.write_data[4:0];
    bank7      = access.write_data[6:0];
    bank_fixed = state.rom_page;
    is_mbc     = (cartridge_kind == KIND_MBC1) || (cartridge_kind == KIND_MBC3);

    if (access.mode == MODE_WRITE && !access.address[15] && is_mbc) begin
      case (access.address[14:13])
        2'd0: begin
          state_next.ram_enable = (access.write_data[3:0] == RAM_ENABLE_KEY);
        end
        2'd1: begin
          // A zero bank number selects bank 1 instead.
          if (cartridge_kind == KIND_MBC1) begin
            if (low5 == 5'd0) begin
              low5 = 5'd1;
            end
            bank_tmp = (16'(state.rom_page) & ~16'h001F) | 16'(low5);
          end else begin
            if (bank7 == 7'd0) begin
              bank7 = 7'd1;
            end
            bank_tmp = 16'(bank7);
          end
          bank_fixed = ROM_PAGE_BITS'(bank_tmp);
          if (bank_fixed == '0) begin
            bank_fixed = ROM_PAGE_BITS'(1);
          end
          state_next.rom_page = bank_fixed;
        end
        2'd2: begin
          if (cartridge_kind == KIND_MBC1) begin
            if (state.banking_mode) begin
              ram_tmp = {6'd0, access.write_data[1:0]};
              state_next.ram_page = RAM_PAGE_BITS'(ram_tmp);
            end else begin
              bank_tmp = (16'(access.write_data[1:0]) << 5) |
                         (16'(state.rom_page) & 16'h001F);
              bank_fixed = ROM_PAGE_BITS'(bank_tmp);
              if (bank_fixed == '0) begin
                bank_fixed = ROM_PAGE_BITS'(1);
              end
              state_next.rom_page = bank_fixed;
            end
          end else if (access.write_data < 8'd4) begin
            // Higher values select clock registers, which are not kept here.
            state_next.ram_page = RAM_PAGE_BITS'(access.write_data);
          end
        end
        default: begin
          if (cartridge_kind == KIND_MBC1) begin
            state_next.banking_mode = access.write_data[0];
          end
        end
      endcase
    end

    if (access.mode == MODE_READ && access.address == ADDR_BOOT_EXIT) begin
      state_next.boot_overlay = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cartridge_kind     <= KIND_ROM_ONLY;
      state.rom_page     <= ROM_PAGE_BITS'(1);
      state.ram_page     <= '0;
      state.ram_enable   <= 1'b0;
      state.banking_mode <= 1'b0;
      state.boot_overlay <= 1'b1;
    end else begin
      if (cfg_we) begin
        cartridge_kind <= cfg_wdata;
      end
      if (update) begin
        state <= state_next;
      end
    end
  end

  a_rom_page_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.rom_page != '0)
    else $error("ROM bank register holds zero");

  a_boot_stays_off: assert property (@(posedge clk) disable iff (rst)
    !state.boot_overlay |=> !state.boot_overlay)
    else $error("boot overlay came back after it was dropped");

  a_rom_only_frozen: assert property (@(posedge clk) disable iff (rst)
    (update && cartridge_kind == KIND_ROM_ONLY) |=>
      $stable(state.rom_page) && $stable(state.ram_page) && $stable(state.ram_enable))
    else $error("bank state changed for a cartridge without a controller");

endmodule

FILE: design/banked_memory_map_decoder_unit.sv
// Memory map decoder with a cartridge bank controller. Each input transaction
// is one CPU bus access (s_tuser is 0 for a read, 1 for a write) and yields
// exactly one output transaction carrying the target region, the physical
// byte offset inside that region with the current ROM or RAM bank applied,
// a sprite DMA flag for a write to 0xFF46 and the RAM enable flag as it
// stands after the access. Writes below 0x8000 update the bank registers by
// the rules of the configured cartridge kind (0 ROM only, 1 MBC1, 2 MBC3;
// 3 behaves as ROM only), and a read of 0x0100 removes the boot overlay.
// The block holds one input register and one result register; an accepted
// transaction goes through both and is presented from the result register.
// A new transaction is accepted in every cycle, so throughput is one access
// per clock while the output side keeps taking results. The bank registers
// are updated as a transaction moves from the input register to the result
// register, so the next access always decodes against the state this one
// left. Write the cartridge kind only while no transaction is in flight.
module banked_memory_map_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // Cartridge kind register.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // Bus accesses in.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  input  logic        s_tuser,   // [0] mode
  // Decoded results out.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [3:0] region, [24:4] offset,
                                 // [25] dma_request, [26] ram_enabled, rest 0
);
  import bmmd_pkg::*;

  // Input register stage.
  logic        in_valid;
  access_t     in_access;

  // Result register stage.
  logic        out_valid;
  region_t     out_region;
  logic [OFFSET_BITS-1:0] out_offset;
  logic        out_dma;
  logic        out_ram_en;

  logic        advance;
  bank_state_t state_next;

  region_t     region_next;
  logic [OFFSET_BITS-1:0] offset_next;
  logic        dma_next;
  logic [15:0] addr;

  // The result register frees whenever its contents are taken, and the input
  // register frees whenever it can move forward.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  bmmd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .update     (advance),
    .access     (in_access),
    .state_next (state_next)
  );

  // Address decode against the bank state after this access. All offsets are
  // plain address bit fields; banked ROM and cartridge RAM put the bank above.
  assign addr = in_access.address;

  always_comb begin
    region_next = REGION_UNUSABLE;
    offset_next = '0;
    dma_next    = 1'b0;
    if (addr < 16'h4000) begin
      // The overlay test sees the flag after this access. Only an access to
      // 0x0100 clears it, and that address lies above the overlay, so the
      // flag before and after the access give the same region here.
      region_next = (state_next.boot_overlay && addr < 16'h0100) ? REGION_BOOT
                                                                  : REGION_ROM0;
      offset_next = OFFSET_BITS'(addr);
    end else if (addr < 16'h8000) begin
      region_next = REGION_ROMN;
      offset_next = OFFSET_BITS'({state_next.rom_page, addr[13:0]});
    end else if (addr < 16'hA000) begin
      region_next = REGION_VIDEO;
      offset_next = OFFSET_BITS'(addr[12:0]);
    end else if (addr < 16'hC000) begin
      // Reported as cartridge RAM whether or not the RAM is enabled.
      region_next = REGION_CARTRAM;
      offset_next = OFFSET_BITS'({state_next.ram_page, addr[12:0]});
    end else if (addr < 16'hFE00) begin
      // Work RAM and its echo image share the low 13 address bits.
      region_next = REGION_WORKRAM;
      offset_next = OFFSET_BITS'(addr[12:0]);
    end else if (addr < 16'hFEA0) begin
      region_next = REGION_SPRITE;
      offset_next = OFFSET_BITS'(addr[7:0]);
    end else if (addr < 16'hFF00) begin
      region_next = REGION_UNUSABLE;
    end else if (addr < 16'hFF4C) begin
      region_next = REGION_IO;
      offset_next = OFFSET_BITS'(addr[7:0]);
      dma_next    = (in_access.mode == MODE_WRITE) && (addr == ADDR_DMA);
    end else if (addr < 16'hFF80) begin
      region_next = REGION_UNUSABLE;
    end else if (addr < 16'hFFFF) begin
      region_next = REGION_HIGHRAM;
      offset_next = OFFSET_BITS'(addr[6:0]);
    end else begin
      region_next = REGION_IRQ_EN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_access.mode       <= s_tuser;
      in_access.address    <= s_tdata[15:0];
      in_access.write_data <= s_tdata[23:16];
    end
    if (advance) begin
      out_region <= region_next;
      out_offset <= offset_next;
      out_dma    <= dma_next;
      out_ram_en <= state_next.ram_enable;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_ram_en, out_dma, out_offset, out_region};

  a_dma_only_io: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_dma) |-> (out_region == REGION_IO))
    else $error("DMA request outside the I/O region");

  a_no_offset_unmapped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_region == REGION_UNUSABLE || out_region == REGION_IRQ_EN))
      |-> (out_offset == '0))
    else $error("nonzero offset for an unmapped or interrupt enable access");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |=> out_valid)
    else $error("held access did not move to the result register");

endmodule
